// ===== hdl/wmsd_pkg.sv =====
// Shared constants and the sequencer state type for the windowed mean and deviation block.
package wmsd_pkg;

  localparam int IN_W       = 24;
  localparam int COUNT_W    = 6;
  localparam int MEAN_W     = 24;
  localparam int STD_W      = 24;
  localparam int VAR_W      = 2 * STD_W;
  localparam int WINDOW_DEF = 60;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_SUMS,
    ST_N_SQ,
    ST_N_SUMSQ,
    ST_SUM_SQ,
    ST_DIV_VAR,
    ST_DIV_MEAN,
    ST_SQRT,
    ST_DONE
  } seq_state_t;

endpackage

// ===== hdl/wmsd_if.sv =====
// Valid/ready channel interfaces for input samples and output statistics.
interface wmsd_in_if;
  import wmsd_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] interval_us;

  modport source (output valid, output interval_us, input ready);
  modport sink   (input valid, input interval_us, output ready);
endinterface

interface wmsd_out_if;
  import wmsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] sample_count;
  logic [MEAN_W-1:0]  mean_us;
  logic [STD_W-1:0]   std_dev_us;

  modport source (output valid, output sample_count, output mean_us, output std_dev_us,
                  input ready);
  modport sink   (input valid, input sample_count, input mean_us, input std_dev_us,
                  output ready);
endinterface

// ===== hdl/wmsd_mul.sv =====
// Serial shift-and-add multiplier that retires one multiplier bit per cycle.
module wmsd_mul #(
  parameter int AW = 2 * wmsd_pkg::IN_W,
  parameter int BW = wmsd_pkg::IN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  import wmsd_pkg::*;

  localparam int PW = AW + BW;

  logic          busy;
  logic [PW-1:0] areg;
  logic [BW-1:0] breg;
  logic [PW-1:0] acc;

  // The run ends as soon as no multiplier bits are left.
  assign done = busy && (breg == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= PW'(a);
      breg <= b;
      acc  <= '0;
    end else if (busy && (breg != '0)) begin
      if (breg[0]) begin
        acc <= acc + areg;
      end
      areg <= areg << 1;
      breg <= breg >> 1;
    end
  end

endmodule

// ===== hdl/wmsd_div.sv =====
// Restoring divider that brings down one dividend bit per cycle.
module wmsd_div #(
  parameter int NW = 2 * wmsd_pkg::IN_W,
  parameter int DW = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NW-1:0]            num,
  input  logic [DW-1:0]            den,
  input  logic [$clog2(NW+1)-1:0]  len,
  output logic                     done,
  output logic [NW-1:0]            quot
);
  import wmsd_pkg::*;

  localparam int LW = $clog2(NW + 1);

  logic          busy;
  logic [NW-1:0] nreg;
  logic [DW-1:0] dreg;
  logic [DW-1:0] rem;
  logic [NW-1:0] qreg;
  logic [LW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;

  // The dividend is left aligned; len says how many of its top bits take part.
  assign done    = busy && (cnt == '0);
  assign quot    = qreg;
  assign rem_sh  = {rem, nreg[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
      dreg <= den;
      rem  <= '0;
      qreg <= '0;
      cnt  <= len;
    end else if (busy && (cnt != '0)) begin
      if (rem_sh >= {1'b0, dreg}) begin
        rem  <= rem_sub[DW-1:0];
        qreg <= {qreg[NW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[DW-1:0];
        qreg <= {qreg[NW-2:0], 1'b0};
      end
      nreg <= nreg << 1;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ===== hdl/wmsd_sqrt.sv =====
// Digit-by-digit integer square root that takes two radicand bits per cycle.
module wmsd_sqrt #(
  parameter int RW = wmsd_pkg::STD_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] v,
  output logic            done,
  output logic [RW-1:0]   root
);
  import wmsd_pkg::*;

  localparam int CNTW = $clog2(RW + 1);

  logic              busy;
  logic [2*RW-1:0]   vreg;
  logic [RW:0]       rem;
  logic [RW-1:0]     rreg;
  logic [CNTW-1:0]   cnt;
  logic [RW+2:0]     rem_sh;
  logic [RW+2:0]     trial;
  logic [RW+2:0]     rem_sub;

  assign done    = busy && (cnt == '0);
  assign root    = rreg;
  assign rem_sh  = {rem, vreg[2*RW-1 -: 2]};
  assign trial   = {1'b0, rreg, 2'b01};
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vreg <= v;
      rem  <= '0;
      rreg <= '0;
      cnt  <= CNTW'(RW);
    end else if (busy && (cnt != '0)) begin
      // The remainder never exceeds twice the partial root, so it fits RW+1 bits.
      if (rem_sh >= trial) begin
        rem  <= rem_sub[RW:0];
        rreg <= {rreg[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RW:0];
        rreg <= {rreg[RW-2:0], 1'b0};
      end
      vreg <= vreg << 2;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ===== hdl/windowed_mean_stddev_top.sv =====
// Top level of the sliding-window mean and standard deviation block.
//
// Each word on the samples channel is one frame interval in microseconds. The block keeps
// the last WINDOW samples, or all samples so far while the window fills, and answers
// every sample with one word on the stats channel: the number of samples held, the floor
// of their mean, and the floor of their population standard deviation, computed exactly
// in integers as floor(sqrt((n*sumsq - sum^2) / n^2)). One sample is worked on at a time.
// A sample passes in turn through the shared serial multiplier, the bit-serial divider and
// the square root unit; the multiplier stops early when the multiplier operand has few
// significant bits. The result sits in an output register, so the next sample is taken
// while the previous result still waits on the stats side. There is no clearing pass
// after reset: a window slot is read only to evict it, and that happens only after it
// has been written.
module windowed_mean_stddev_top #(
  parameter int WINDOW = wmsd_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wmsd_in_if.sink     samples,
  wmsd_out_if.source  stats
);
  import wmsd_pkg::*;

  localparam int CW   = $clog2(WINDOW + 1);              // held count
  localparam int SW   = IN_W + CW;                       // running sum
  localparam int SQW  = 2 * IN_W + CW;                   // running sum of squares
  localparam int NUMW = SQW + CW;                        // variance numerator
  localparam int DW   = 2 * CW;                          // n squared
  localparam int SLW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LW   = $clog2(NUMW + 1);
  localparam int MAW  = SQW;
  localparam int MBW  = SW;

  // Sequencer state.
  seq_state_t state;
  seq_state_t state_next;
  logic       op_run;

  // Window bookkeeping.
  logic [IN_W-1:0] sample_store [WINDOW];
  logic [SLW-1:0]  write_slot;
  logic [CW-1:0]   held_count;
  logic [SW-1:0]   run_sum;
  logic [SQW-1:0]  run_sumsq;
  logic            window_full;
  logic            was_full;

  // Working registers for one sample.
  logic [IN_W-1:0]   new_sample;
  logic [IN_W-1:0]   old_sample;
  logic [2*IN_W-1:0] new_sq;
  logic [2*IN_W-1:0] old_sq;
  logic [DW-1:0]     n_sq;
  logic [NUMW-1:0]   n_sumsq;
  logic [NUMW-1:0]   numer;
  logic [VAR_W-1:0]  var_q;
  logic [MEAN_W-1:0] mean_q;

  // Output register.
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic [MEAN_W-1:0]  out_mean;
  logic [STD_W-1:0]   out_std;
  logic               out_free;

  // Arithmetic unit controls.
  logic               mul_start;
  logic [MAW-1:0]     mul_a;
  logic [MBW-1:0]     mul_b;
  logic               mul_done;
  logic [MAW+MBW-1:0] mul_prod;
  logic               div_start;
  logic [NUMW-1:0]    div_num;
  logic [DW-1:0]      div_den;
  logic [LW-1:0]      div_len;
  logic               div_done;
  logic [NUMW-1:0]    div_quot;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [STD_W-1:0]   sqrt_root;
  logic               unit_done;

  logic take;

  assign samples.ready = (state == ST_IDLE);
  assign take          = samples.valid && samples.ready;
  assign window_full   = (held_count == CW'(WINDOW));
  assign out_free      = !out_valid || stats.ready;

  assign stats.valid        = out_valid;
  assign stats.sample_count = out_count;
  assign stats.mean_us      = out_mean;
  assign stats.std_dev_us   = out_std;

  // The new sample overwrites the oldest slot in the same cycle that the slot is read,
  // so the registered read data holds the value that leaves the window.
  always_ff @(posedge clk) begin
    if (take) begin
      sample_store[write_slot] <= samples.interval_us;
      old_sample               <= sample_store[write_slot];
    end
  end

  wmsd_mul #(
    .AW (MAW),
    .BW (MBW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  wmsd_div #(
    .NW (NUMW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .len   (div_len),
    .done  (div_done),
    .quot  (div_quot)
  );

  wmsd_sqrt #(
    .RW (STD_W)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .v     (var_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) state_next = ST_SQ_NEW;
      end
      ST_SQ_NEW: begin
        if (mul_done) state_next = was_full ? ST_SQ_OLD : ST_SUMS;
      end
      ST_SQ_OLD: begin
        if (mul_done) state_next = ST_SUMS;
      end
      ST_SUMS: begin
        state_next = ST_N_SQ;
      end
      ST_N_SQ: begin
        if (mul_done) state_next = ST_N_SUMSQ;
      end
      ST_N_SUMSQ: begin
        if (mul_done) state_next = ST_SUM_SQ;
      end
      ST_SUM_SQ: begin
        if (mul_done) state_next = ST_DIV_VAR;
      end
      ST_DIV_VAR: begin
        if (div_done) state_next = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (div_done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Unit starts and operand selection. Each arithmetic phase starts its unit in its first
  // cycle and then waits for the unit to finish.
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    div_len    = '0;
    sqrt_start = 1'b0;
    unit_done  = 1'b0;
    unique case (state)
      ST_SQ_NEW: begin
        mul_start = !op_run;
        mul_a     = MAW'(new_sample);
        mul_b     = MBW'(new_sample);
        unit_done = mul_done;
      end
      ST_SQ_OLD: begin
        mul_start = !op_run;
        mul_a     = MAW'(old_sample);
        mul_b     = MBW'(old_sample);
        unit_done = mul_done;
      end
      ST_N_SQ: begin
        mul_start = !op_run;
        mul_a     = MAW'(held_count);
        mul_b     = MBW'(held_count);
        unit_done = mul_done;
      end
      ST_N_SUMSQ: begin
        mul_start = !op_run;
        mul_a     = run_sumsq;
        mul_b     = MBW'(held_count);
        unit_done = mul_done;
      end
      ST_SUM_SQ: begin
        mul_start = !op_run;
        mul_a     = MAW'(run_sum);
        mul_b     = run_sum;
        unit_done = mul_done;
      end
      ST_DIV_VAR: begin
        div_start = !op_run;
        div_num   = numer;
        div_den   = n_sq;
        div_len   = LW'(NUMW);
        unit_done = div_done;
      end
      ST_DIV_MEAN: begin
        // The sum is placed at the top of the dividend so only its own bits are run.
        div_start = !op_run;
        div_num   = {run_sum, {(NUMW-SW){1'b0}}};
        div_den   = DW'(held_count);
        div_len   = LW'(SW);
        unit_done = div_done;
      end
      ST_SQRT: begin
        sqrt_start = !op_run;
        unit_done  = sqrt_done;
      end
      default: begin
      end
    endcase
  end

  // Control registers and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op_run     <= 1'b0;
      write_slot <= '0;
      held_count <= '0;
      run_sum    <= '0;
      run_sumsq  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (mul_start || div_start || sqrt_start) begin
        op_run <= 1'b1;
      end else if (unit_done) begin
        op_run <= 1'b0;
      end

      if (take) begin
        write_slot <= (write_slot == SLW'(WINDOW - 1)) ? '0 : SLW'(write_slot + 1'b1);
        if (!window_full) begin
          held_count <= CW'(held_count + 1'b1);
        end
      end

      // The evicted sample leaves the sums only when the window was already full.
      if (state == ST_SUMS) begin
        run_sum   <= run_sum + SW'(new_sample) - (was_full ? SW'(old_sample) : '0);
        run_sumsq <= run_sumsq + SQW'(new_sq) - (was_full ? SQW'(old_sq) : '0);
      end

      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (stats.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (take) begin
      new_sample <= samples.interval_us;
      was_full   <= window_full;
    end

    case (state)
      ST_SQ_NEW: begin
        if (mul_done) new_sq <= mul_prod[2*IN_W-1:0];
      end
      ST_SQ_OLD: begin
        if (mul_done) old_sq <= mul_prod[2*IN_W-1:0];
      end
      ST_N_SQ: begin
        if (mul_done) n_sq <= mul_prod[DW-1:0];
      end
      ST_N_SUMSQ: begin
        if (mul_done) n_sumsq <= mul_prod[NUMW-1:0];
      end
      ST_SUM_SQ: begin
        if (mul_done) numer <= n_sumsq - mul_prod[NUMW-1:0];
      end
      ST_DIV_VAR: begin
        if (div_done) var_q <= div_quot[VAR_W-1:0];
      end
      ST_DIV_MEAN: begin
        if (div_done) mean_q <= div_quot[MEAN_W-1:0];
      end
      default: begin
      end
    endcase

    if ((state == ST_DONE) && out_free) begin
      out_count <= COUNT_W'(held_count);
      out_mean  <= mean_q;
      out_std   <= sqrt_root;
    end
  end

endmodule

// ===== test/windowed_mean_stddev_top_tb.sv =====
// Self-checking testbench for the sliding-window mean and standard deviation block.
module windowed_mean_stddev_top_tb;
  import wmsd_pkg::*;

  // Total number of sample words, directed rows included.
  localparam int TOTAL_WORDS = 1975;
  // The sender stops and lets the block drain completely this often.
  localparam int DRAIN_EVERY = 400;
  // Cycles to watch for stray words once nothing is expected any more.
  localparam int TAIL_CYCLES = 300;
  // Room for expected words in flight; the block never holds more than two.
  localparam int WANT_DEPTH = 16;
  localparam logic [IN_W-1:0] MAX_INTERVAL = {IN_W{1'b1}};

  // One statistics word as the block returns it.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [STD_W-1:0]   std_dev;
  } stats_t;

  // One row of the directed table. When has_fixed is set, the expected
  // statistics are the typed-in ones; otherwise the window predictor decides.
  typedef struct packed {
    logic [IN_W-1:0]    interval;
    logic               has_fixed;
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [STD_W-1:0]   std_dev;
  } stim_row_t;

  // Content styles for the random part. A style runs for 20 to 150 samples,
  // so it may end before it has filled the 60-sample window.
  typedef enum int {
    MIX_UNIFORM,
    MIX_FRAME_JITTER,
    MIX_CONSTANT,
    MIX_ALTERNATE,
    MIX_SMALL,
    MIX_CORNERS
  } sample_mix_t;

  // Stall styles of the stats receiver.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_CHOKED
  } rx_mode_t;

  localparam int DIRECTED_N = 14;

  // After reset the first sample stands alone: mean is the sample, spread is
  // zero. A full-scale second sample puts the mean and the deviation both at
  // half of full scale, rounded down. Everything else goes to the predictor.
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{24'd0,        1'b1, 6'd1, 24'd0,       24'd0},
    '{MAX_INTERVAL, 1'b1, 6'd2, 24'd8388607, 24'd8388607},
    '{MAX_INTERVAL, 1'b0, 6'd0, 24'd0,       24'd0},
    '{24'd0,        1'b0, 6'd0, 24'd0,       24'd0},
    '{24'd1,        1'b0, 6'd0, 24'd0,       24'd0},
    '{24'h555555,   1'b0, 6'd0, 24'd0,       24'd0},
    '{24'hAAAAAA,   1'b0, 6'd0, 24'd0,       24'd0},
    '{24'h800000,   1'b0, 6'd0, 24'd0,       24'd0},
    '{24'h7FFFFF,   1'b0, 6'd0, 24'd0,       24'd0},
    '{24'd16667,    1'b0, 6'd0, 24'd0,       24'd0},
    '{24'd16667,    1'b0, 6'd0, 24'd0,       24'd0},
    '{24'd16666,    1'b0, 6'd0, 24'd0,       24'd0},
    '{24'hFFFFFE,   1'b0, 6'd0, 24'd0,       24'd0},
    '{24'd0,        1'b0, 6'd0, 24'd0,       24'd0}
  };

  logic clk = 1'b0;
  logic rst;

  wmsd_in_if  samples_ch ();
  wmsd_out_if stats_ch ();

  windowed_mean_stddev_top #(
    .WINDOW(WINDOW_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .stats   (stats_ch)
  );

  // Period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The predictor keeps its own copy of the sliding window: the ring of held
  // samples, the next slot to overwrite, how many samples are held, and the
  // running sum and sum of squares. Sums are kept exact in 64 bits, which is
  // plenty for 60 samples of 24 bits.
  logic [IN_W-1:0] window_mem [WINDOW_DEF];
  int unsigned     next_slot;
  int unsigned     held;
  logic [63:0]     win_sum;
  logic [63:0]     win_sumsq;

  // Expected words in arrival order, kept in a small ring with free-running
  // write and read counts.
  stats_t      want_mem [WANT_DEPTH];
  int unsigned want_wr;
  int unsigned want_rd;
  int          mismatch_count;
  int          words_sent;

  // Content generator state for the random part.
  sample_mix_t     mix;
  int              mix_left;
  logic [IN_W-1:0] mix_base;
  logic [IN_W-1:0] mix_alt;
  int              mix_jitter;
  logic            alt_phase;

  // Floor of the square root, one result bit at a time from the top.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0]  root;
    logic [63:0]  trial;
    logic [127:0] trial_sq;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial    = root | (64'd1 << b);
      trial_sq = {64'd0, trial} * {64'd0, trial};
      if (trial_sq <= {64'd0, v}) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Takes one sample into the window and returns the statistics the block
  // must answer with. Until the window is full nothing is evicted; after
  // that the oldest sample, which sits in the slot about to be written,
  // leaves the sums before the new one enters. The variance numerator
  // n*sumsq - sum^2 is formed in 128 bits, so it is exact for any window.
  function automatic stats_t advance_window(input logic [IN_W-1:0] x);
    logic [IN_W-1:0] oldest;
    logic [127:0]    n_w;
    logic [127:0]    numer;
    logic [127:0]    quot;
    logic [63:0]     mean_full;
    logic [63:0]     root;
    stats_t          result;
    if (held >= WINDOW_DEF) begin
      oldest    = window_mem[next_slot];
      win_sum   = win_sum - {40'd0, oldest};
      win_sumsq = win_sumsq - {40'd0, oldest} * {40'd0, oldest};
    end else begin
      held = held + 1;
    end
    window_mem[next_slot] = x;
    win_sum   = win_sum + {40'd0, x};
    win_sumsq = win_sumsq + {40'd0, x} * {40'd0, x};
    next_slot = (next_slot + 1 >= WINDOW_DEF) ? 0 : next_slot + 1;

    n_w       = 128'(held);
    numer     = n_w * {64'd0, win_sumsq} - {64'd0, win_sum} * {64'd0, win_sum};
    quot      = numer / (n_w * n_w);
    root      = int_sqrt(quot[63:0]);
    mean_full = win_sum / 64'(held);

    result.count   = held[COUNT_W-1:0];
    result.mean    = mean_full[MEAN_W-1:0];
    result.std_dev = root[STD_W-1:0];
    return result;
  endfunction

  // Picks the next random sample. A new content style is chosen whenever the
  // current one runs out, with a fresh base value and spread for it.
  function automatic logic [IN_W-1:0] next_interval();
    logic [IN_W-1:0] value;
    if (mix_left == 0) begin
      mix        = sample_mix_t'($urandom_range(0, 5));
      mix_left   = $urandom_range(20, 150);
      mix_jitter = $urandom_range(0, 600);
      case ($urandom_range(0, 3))
        0: mix_base = 24'd16667;
        1: mix_base = 24'd33333;
        2: mix_base = 24'd41667;
        default: mix_base = IN_W'($urandom_range(1000, 24'hFFF000));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        mix_alt = MAX_INTERVAL;
        if (mix == MIX_ALTERNATE) mix_base = '0;
      end else begin
        mix_alt = IN_W'($urandom());
      end
    end
    mix_left = mix_left - 1;
    case (mix)
      MIX_UNIFORM: value = IN_W'($urandom());
      MIX_FRAME_JITTER: begin
        value = mix_base + IN_W'($urandom_range(0, 2 * mix_jitter)) - IN_W'(mix_jitter);
      end
      MIX_CONSTANT: value = mix_base;
      MIX_ALTERNATE: begin
        alt_phase = ~alt_phase;
        value = alt_phase ? mix_alt : mix_base;
      end
      MIX_SMALL: value = IN_W'($urandom_range(0, 300));
      default: begin
        case ($urandom_range(0, 5))
          0: value = '0;
          1: value = MAX_INTERVAL;
          2: value = 24'd1;
          3: value = MAX_INTERVAL - 1;
          4: value = 24'h800000;
          default: value = IN_W'($urandom());
        endcase
      end
    endcase
    return value;
  endfunction

  // Presents one sample word from the falling edge on and holds it until the
  // block takes it. On acceptance the expected statistics are queued.
  task automatic send_word(input logic [IN_W-1:0] value, input logic has_fixed,
                           input stats_t fixed_stats);
    stats_t predicted;
    @(negedge clk);
    samples_ch.valid       <= 1'b1;
    samples_ch.interval_us <= value;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    predicted = advance_window(value);
    want_mem[want_wr % WANT_DEPTH] = has_fixed ? fixed_stats : predicted;
    want_wr    = want_wr + 1;
    words_sent = words_sent + 1;
  endtask

  // Leaves the samples channel idle for the given number of cycles.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      samples_ch.valid <= 1'b0;
    end
  endtask

  // Holds the sender back until every queued result has come out.
  task automatic wait_drained();
    while (want_wr != want_rd) @(posedge clk);
  endtask

  // Stats receiver. It switches at random between stall styles: always ready,
  // random stalls, a fixed duty pattern, and a mostly stalled style that keeps
  // results sitting in the output register.
  initial begin : stats_receiver
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_phase;
    stats_ch.ready = 1'b0;
    rx_mode  = RX_ALWAYS;
    rx_left  = 0;
    rx_phase = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(64, 400);
      end
      rx_left  = rx_left - 1;
      rx_phase = (rx_phase + 1) % 7;
      case (rx_mode)
        RX_ALWAYS:  stats_ch.ready <= 1'b1;
        RX_RANDOM:  stats_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: stats_ch.ready <= (rx_phase < 3);
        default:    stats_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Result checker. Every accepted stats word is matched against the oldest
  // expectation; a word with nothing waiting is a failure of its own.
  stats_t want_stats;

  always @(posedge clk) begin
    if (!rst && stats_ch.valid && stats_ch.ready) begin
      if (want_wr == want_rd) begin
        $error("Unexpected stats word: sample_count %0d mean_us %0d std_dev_us %0d",
               stats_ch.sample_count, stats_ch.mean_us, stats_ch.std_dev_us);
        mismatch_count = mismatch_count + 1;
      end else begin
        want_stats = want_mem[want_rd % WANT_DEPTH];
        want_rd    = want_rd + 1;
        if (stats_ch.sample_count !== want_stats.count) begin
          $error("sample_count: expected %0d, actual %0d",
                 want_stats.count, stats_ch.sample_count);
          mismatch_count = mismatch_count + 1;
        end
        if (stats_ch.mean_us !== want_stats.mean) begin
          $error("mean_us: expected %0d, actual %0d", want_stats.mean, stats_ch.mean_us);
          mismatch_count = mismatch_count + 1;
        end
        if (stats_ch.std_dev_us !== want_stats.std_dev) begin
          $error("std_dev_us: expected %0d, actual %0d",
                 want_stats.std_dev, stats_ch.std_dev_us);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Main sequence: reset, the directed table, then random bursts of samples
  // with random gaps. Gaps range from none to longer than one sample's whole
  // computation, so the next word lands on every phase of the block's work.
  initial begin : sample_sender
    int     burst_len;
    int     gap;
    int     last_drain;
    stats_t row_stats;
    rst                    = 1'b1;
    samples_ch.valid       = 1'b0;
    samples_ch.interval_us = '0;
    next_slot      = 0;
    held           = 0;
    win_sum        = '0;
    win_sumsq      = '0;
    want_wr        = 0;
    want_rd        = 0;
    mismatch_count = 0;
    words_sent     = 0;
    mix            = MIX_UNIFORM;
    mix_left       = 0;
    mix_base       = '0;
    mix_alt        = '0;
    mix_jitter     = 0;
    alt_phase      = 1'b0;
    last_drain     = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row_stats.count   = directed_rows[i].count;
      row_stats.mean    = directed_rows[i].mean;
      row_stats.std_dev = directed_rows[i].std_dev;
      send_word(directed_rows[i].interval, directed_rows[i].has_fixed, row_stats);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 20));
    end

    // Let everything drain once before the random part begins.
    idle_cycles(1);
    wait_drained();

    while (words_sent < TOTAL_WORDS) begin
      burst_len = $urandom_range(1, 16);
      for (int i = 0; i < burst_len && words_sent < TOTAL_WORDS; i++) begin
        send_word(next_interval(), 1'b0, '0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 12);
        8:          gap = $urandom_range(20, 80);
        default:    gap = $urandom_range(100, 260);
      endcase
      idle_cycles(gap);
      if (words_sent - last_drain >= DRAIN_EVERY) begin
        idle_cycles(1);
        wait_drained();
        last_drain = words_sent;
      end
    end

    idle_cycles(1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run of all the samples.
  initial begin : watchdog
    #60000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== windowed_mean_stddev_top.f =====
hdl/wmsd_pkg.sv
hdl/wmsd_if.sv
hdl/wmsd_mul.sv
hdl/wmsd_div.sv
hdl/wmsd_sqrt.sv
hdl/windowed_mean_stddev_top.sv
test/windowed_mean_stddev_top_tb.sv
